FILE: hw/rtl/servo_status_frame_parser_macros.svh
// Assertion macros used by the parser RTL.
`ifndef SERVO_STATUS_FRAME_PARSER_MACROS_SVH
`define SERVO_STATUS_FRAME_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clock, off while reset is high
`define SSFP_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SSFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SSFP_ASSERT(label, ante, cons, msg)
`define SSFP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/ssfp_pkg.sv
package ssfp_pkg;

   localparam int MAX_LENGTH_DEF = 29;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;

   localparam logic [1:0] KIND_PARAM   = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_BAD_LEN = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_slot_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] servo_id;
      logic [7:0] status_error;
      logic [7:0] frame_length;
      logic [4:0] param_index;
      logic [7:0] value;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_slot_type;

endpackage

FILE: hw/rtl/ssfp_channels.sv
interface ssfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] servo_id;
   logic [7:0] status_error;
   logic [7:0] frame_length;
   logic [4:0] param_index;
   logic [7:0] value;
   logic       last;

   modport source (output valid, output kind, output servo_id, output status_error,
                   output frame_length, output param_index, output value,
                   output last, input ready);
   modport sink (input valid, input kind, input servo_id, input status_error,
                 input frame_length, input param_index, input value,
                 input last, output ready);
endinterface

FILE: hw/rtl/ssfp_in_reg.sv
module ssfp_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   ssfp_req_if.sink               req_bus,
   input  logic                   advance,
   output ssfp_pkg::byte_slot_type slot
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_bus.ready = !valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_bus.rx_byte;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.data  = byte_ff;

endmodule

FILE: hw/rtl/ssfp_parser.sv
`include "servo_status_frame_parser_macros.svh"

module ssfp_parser #(
   parameter int MAX_LENGTH = ssfp_pkg::MAX_LENGTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ssfp_pkg::byte_slot_type slot,
   input  logic                    out_free,
   output logic                    advance,
   output ssfp_pkg::rsp_slot_type  res
);

   // count reaches at most MAX_LENGTH-3 in the parameter phase, 2 in the header
   localparam int CNT_W = ($clog2(MAX_LENGTH) > 2) ? $clog2(MAX_LENGTH) : 2;
   localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_LENGTH);

   localparam logic [1:0] PH_HUNT   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;
   localparam logic [1:0] PH_CHECK  = 2'd3;

   logic [1:0]       phase_ff,  phase_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [7:0]       id_ff,     id_in;
   logic [7:0]       length_ff, length_in;
   logic [7:0]       error_ff,  error_in;

   logic       has_result;
   logic [1:0] kind;
   logic [4:0] index;
   logic [7:0] value;
   logic       last;
   logic       bad_length;
   logic       data_done;
   logic [7:0] b;

   assign b          = slot.data;
   assign bad_length = (length_ff < 8'd2) || (length_ff > MAX_LEN_BYTE);
   assign data_done  = (9'(count_ff) + 9'd3) >= {1'b0, length_ff};

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      id_in      = id_ff;
      length_in  = length_ff;
      error_in   = error_ff;
      has_result = 1'b0;
      kind       = ssfp_pkg::KIND_PARAM;
      index      = 5'd0;
      value      = 8'd0;
      last       = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (b == ssfp_pkg::PREAMBLE_BYTE) begin
               if (count_ff != '0) begin
                  count_in = '0;
                  phase_in = PH_HEADER;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               count_in = '0;
            end
         end
         PH_HEADER: begin
            priority if (count_ff == CNT_W'(0)) begin
               id_in = b;
            end else if (count_ff == CNT_W'(1)) begin
               length_in = b;
            end else begin
               error_in = b;
            end
            if (count_ff == CNT_W'(2)) begin
               count_in = '0;
               if (bad_length) begin
                  phase_in   = PH_HUNT;
                  has_result = 1'b1;
                  kind       = ssfp_pkg::KIND_BAD_LEN;
                  last       = 1'b1;
               end else if (length_ff == 8'd2) begin
                  phase_in = PH_CHECK;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         PH_DATA: begin
            has_result = 1'b1;
            kind       = ssfp_pkg::KIND_PARAM;
            index      = 5'(count_ff);
            value      = b;
            if (data_done) begin
               count_in = '0;
               phase_in = PH_CHECK;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         PH_CHECK: begin
            has_result = 1'b1;
            kind       = ssfp_pkg::KIND_END;
            value      = b;
            last       = 1'b1;
            phase_in   = PH_HUNT;
            count_in   = '0;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   assign advance = slot.valid && (!has_result || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         count_ff  <= '0;
         id_ff     <= 8'd0;
         length_ff <= 8'd0;
         error_ff  <= 8'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         error_ff  <= error_in;
      end
   end

   // header fields reflect the byte being parsed, so the error word carries it
   assign res.valid             = advance && has_result;
   assign res.word.kind         = kind;
   assign res.word.servo_id     = id_in;
   assign res.word.status_error = error_in;
   assign res.word.frame_length = length_in;
   assign res.word.param_index  = index;
   assign res.word.value        = value;
   assign res.word.last         = last;

   `SSFP_ASSERT(a_data_len_ok, phase_ff == PH_DATA,
      (length_ff > 8'd2) && (length_ff <= MAX_LEN_BYTE),
      "parameter phase entered with a bad length")
   `SSFP_ASSERT(a_data_count_ok, phase_ff == PH_DATA,
      (9'(count_ff) + 9'd2) < {1'b0, length_ff},
      "parameter count ran past the frame length")
   `SSFP_ASSERT(a_hunt_count_ok, phase_ff == PH_HUNT, count_ff <= CNT_W'(1),
      "preamble count out of range")
   `SSFP_ASSERT_NEXT(a_preamble_done,
      advance && (phase_ff == PH_HUNT) && (count_ff == CNT_W'(1)) &&
      (b == ssfp_pkg::PREAMBLE_BYTE),
      (phase_ff == PH_HEADER) && (count_ff == '0),
      "second preamble byte did not start the header")

endmodule

FILE: hw/rtl/ssfp_out_reg.sv
module ssfp_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  ssfp_pkg::rsp_slot_type res,
   output logic                   out_free,
   ssfp_rsp_if.source             rsp_bus
);

   logic                   valid_ff;
   logic                   valid_in;
   ssfp_pkg::rsp_word_type word_ff;

   assign out_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      if (res.valid) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         word_ff <= res.word;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.kind         = word_ff.kind;
   assign rsp_bus.servo_id     = word_ff.servo_id;
   assign rsp_bus.status_error = word_ff.status_error;
   assign rsp_bus.frame_length = word_ff.frame_length;
   assign rsp_bus.param_index  = word_ff.param_index;
   assign rsp_bus.value        = word_ff.value;
   assign rsp_bus.last         = word_ff.last;

endmodule

FILE: hw/rtl/servo_status_frame_parser.sv
// Status frame parser for a half-duplex servo bus.
// req_bus carries one received line byte per word. The parser hunts for two
// 0xFF bytes in a row, takes id, length and error, then reports each
// parameter byte (kind 0, with its index) and finally the checksum byte
// (kind 1, last set). The checksum is not verified. A length below 2 or above
// MAX_LENGTH gives one kind 2 word with last set and the parser goes back
// to hunting. Otherwise header and preamble bytes produce no rsp_bus word.
// A byte taken into the input register passes through the parse logic into
// the output register, from which it appears on rsp_bus.
// Throughput: one byte per cycle unless stalled; parse state is registered.
// When rsp_bus stalls, the output register holds its word and the input
// register still takes one more byte; req_bus.ready drops only when both are
// full. Bytes that produce no word keep flowing through a stalled output.
// Reset (synchronous) empties both registers and restarts preamble hunting.
module servo_status_frame_parser #(
   parameter int MAX_LENGTH = ssfp_pkg::MAX_LENGTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ssfp_req_if.sink    req_bus,
   ssfp_rsp_if.source  rsp_bus
);

   ssfp_pkg::byte_slot_type slot;
   ssfp_pkg::rsp_slot_type  res;
   logic                    advance;
   logic                    out_free;

   ssfp_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .advance (advance),
      .slot    (slot)
   );

   ssfp_parser #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .slot     (slot),
      .out_free (out_free),
      .advance  (advance),
      .res      (res)
   );

   ssfp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .res      (res),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: tb/sv/ssfp_frame_checker.sv
`timescale 1ns / 100ps

module ssfp_frame_checker (
   input  logic        clock,
   input  logic        reset,
   ssfp_req_if         req_bus,
   ssfp_rsp_if         rsp_bus,
   output int unsigned fail_count,
   output int unsigned words_checked,
   output int unsigned words_pending
);

   typedef enum logic [1:0] {
      HUNT_PREAMBLE,
      TAKE_HEADER,
      TAKE_PARAMS,
      TAKE_CHECKSUM
   } parse_phase_type;

   parse_phase_type parse_phase;
   logic [4:0]      byte_count;
   logic [7:0]      hdr_id;
   logic [7:0]      hdr_length;
   logic [7:0]      hdr_error;

   ssfp_pkg::rsp_word_type expected_words[$];
   int unsigned            fail_total;
   int unsigned            checked_total;

   function automatic ssfp_pkg::rsp_word_type make_word(logic [1:0] kind, logic [4:0] index,
                                                        logic [7:0] value, logic last);
      ssfp_pkg::rsp_word_type w;
      w.kind         = kind;
      w.servo_id     = hdr_id;
      w.status_error = hdr_error;
      w.frame_length = hdr_length;
      w.param_index  = index;
      w.value        = value;
      w.last         = last;
      return w;
   endfunction

   // advance the parse state by one line byte, queue the word it yields
   function automatic void predict_byte(logic [7:0] b);
      unique case (parse_phase)
         HUNT_PREAMBLE: begin
            if (b != ssfp_pkg::PREAMBLE_BYTE) begin
               byte_count = '0;
            end else if (byte_count == 5'd1) begin
               byte_count  = '0;
               parse_phase = TAKE_HEADER;
            end else begin
               byte_count = 5'd1;
            end
         end
         TAKE_HEADER: begin
            unique case (byte_count)
               5'd0:    hdr_id     = b;
               5'd1:    hdr_length = b;
               default: hdr_error  = b;
            endcase
            if (byte_count != 5'd2) begin
               byte_count = byte_count + 5'd1;
            end else begin
               byte_count = '0;
               if (hdr_length < 8'd2 || int'(hdr_length) > ssfp_pkg::MAX_LENGTH_DEF) begin
                  expected_words.push_back(make_word(ssfp_pkg::KIND_BAD_LEN, 5'd0, 8'h00,
                                                     1'b1));
                  parse_phase = HUNT_PREAMBLE;
               end else if (hdr_length == 8'd2) begin
                  parse_phase = TAKE_CHECKSUM;
               end else begin
                  parse_phase = TAKE_PARAMS;
               end
            end
         end
         TAKE_PARAMS: begin
            expected_words.push_back(make_word(ssfp_pkg::KIND_PARAM, byte_count, b, 1'b0));
            if (int'(byte_count) + 3 >= int'(hdr_length)) begin
               byte_count  = '0;
               parse_phase = TAKE_CHECKSUM;
            end else begin
               byte_count = byte_count + 5'd1;
            end
         end
         default: begin
            expected_words.push_back(make_word(ssfp_pkg::KIND_END, 5'd0, b, 1'b1));
            byte_count  = '0;
            parse_phase = HUNT_PREAMBLE;
         end
      endcase
   endfunction

   function automatic int unsigned field_diff(string name, int unsigned want,
                                              int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      ssfp_pkg::rsp_word_type want;
      int unsigned            bad;
      if (reset) begin
         parse_phase = HUNT_PREAMBLE;
         byte_count  = '0;
         hdr_id      = '0;
         hdr_length  = '0;
         hdr_error   = '0;
         expected_words.delete();
         fail_total    = 0;
         checked_total = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_byte(req_bus.rx_byte);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: kind %0d value %0d", rsp_bus.kind, rsp_bus.value);
               fail_total++;
            end else begin
               want = expected_words.pop_front();
               bad  = field_diff("kind", 32'(want.kind), 32'(rsp_bus.kind))
                    + field_diff("servo_id", 32'(want.servo_id), 32'(rsp_bus.servo_id))
                    + field_diff("status_error", 32'(want.status_error),
                                 32'(rsp_bus.status_error))
                    + field_diff("frame_length", 32'(want.frame_length),
                                 32'(rsp_bus.frame_length))
                    + field_diff("param_index", 32'(want.param_index),
                                 32'(rsp_bus.param_index))
                    + field_diff("value", 32'(want.value), 32'(rsp_bus.value))
                    + field_diff("last", 32'(want.last), 32'(rsp_bus.last));
               fail_total += bad;
            end
            checked_total++;
         end
      end
      fail_count    <= fail_total;
      words_checked <= checked_total;
      words_pending <= expected_words.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   logic clock;
   logic reset;

   ssfp_req_if req_bus ();
   ssfp_rsp_if rsp_bus ();

   int unsigned fail_count;
   int unsigned words_checked;
   int unsigned words_pending;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_requests;
   int unsigned bytes_sent;
   int unsigned frames_sent;
   int unsigned bad_frames;

   servo_status_frame_parser i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ssfp_frame_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .words_checked (words_checked),
      .words_pending (words_pending)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold whenever one is requested
   initial begin : receiver
      int unsigned hold_left;
      int unsigned hold_served;
      hold_left     = 0;
      hold_served   = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_served != hold_requests) begin
            hold_served++;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err);
      int unsigned k;
      send_byte(ssfp_pkg::PREAMBLE_BYTE);
      send_byte(ssfp_pkg::PREAMBLE_BYTE);
      send_byte(id);
      send_byte(len);
      send_byte(err);
      if (len >= 8'd2 && int'(len) <= ssfp_pkg::MAX_LENGTH_DEF) begin
         for (k = 0; k + 2 < int'(len); k++) send_byte(8'($urandom_range(255)));
         send_byte(8'($urandom_range(255)));
      end else begin
         bad_frames++;
      end
      frames_sent++;
   endtask

   // sender goes quiet until every expected word has come back
   task automatic drain;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned target;
      int unsigned pick;
      logic [7:0]  len;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            len = ($urandom_range(9) == 0) ? 8'd29 : 8'($urandom_range(2, 29));
            send_frame(8'($urandom_range(255)), len, 8'($urandom_range(255)));
         end else if (pick < 78) begin
            len = $urandom_range(1) ? 8'($urandom_range(1)) : 8'($urandom_range(30, 255));
            send_frame(8'($urandom_range(255)), len, 8'($urandom_range(255)));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) begin
               send_byte(($urandom_range(3) == 0) ? ssfp_pkg::PREAMBLE_BYTE
                                                  : 8'($urandom_range(255)));
            end
         end else begin
            // lone 0xFF followed by something else
            send_byte(ssfp_pkg::PREAMBLE_BYTE);
            send_byte(8'($urandom_range(254)));
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      send_idle_pct   = 27;
      recv_idle_pct   = 51;
      hold_requests   = 0;
      bytes_sent      = 0;
      frames_sent     = 0;
      bad_frames      = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_byte(ssfp_pkg::PREAMBLE_BYTE);
      send_byte(8'h00);
      send_frame(8'h05, 8'd1, 8'h00);
      send_frame(8'h00, 8'd2, 8'hFF);
      send_frame(8'hFF, 8'd3, 8'h80);
      send_frame(8'h01, 8'd30, 8'h00);
      drain();

      run_random(460);
      drain();

      send_idle_pct = 51;
      recv_idle_pct = 27;
      run_random(460);
      drain();

      // no idling; a long receiver hold lets the parser back up into req_bus
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      repeat (4) send_frame(8'($urandom_range(255)), 8'd29, 8'($urandom_range(255)));
      run_random(350);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d frames (%0d with bad length) plus noise bytes.",
               bytes_sent, frames_sent, bad_frames);
      $display("Checked %0d result words across idle, stall and long-hold traffic.",
               words_checked);
      if (fail_count == 0 && words_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
